@@ hdl/mfs_pkg.sv @@
`timescale 1ns / 1ps

package mfs_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int POS_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int WIN_N     = 9;
    localparam int MED_RANK  = 4;
    localparam int MIN_DIM   = 3;
    localparam int RESET_DIM = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int RANK_W = $clog2(WIN_N);

    // wide enough for the register, either size limit and a counter plus one
    localparam int DIM_A = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
    localparam int DIM_W = (DIM_A > ROW_W + 1) ? DIM_A : ROW_W + 1;

    // result queue, power of two deep
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [WIN_N-1:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic             emit;
        logic             done;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_pos_info;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } t_result;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [CFG_W-1:0] cfg,
        input logic [DIM_W-1:0] hi
    );
        logic [DIM_W-1:0] v;
        v = DIM_W'(cfg);
        if (v < DIM_W'(MIN_DIM)) begin
            return DIM_W'(MIN_DIM);
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

@@ hdl/mfs_ram.sv @@
`timescale 1ns / 1ps

module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/mfs_window.sv @@
`timescale 1ns / 1ps

module mfs_window import mfs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [COL_W-1:0] i_col,
    output t_window          o_window
);

    logic             r_v1;
    logic [PIX_W-1:0] r_px1;
    logic [COL_W-1:0] r_col1;
    logic [PIX_W-1:0] w_up;
    logic [PIX_W-1:0] w_mid;
    t_window          r_win;
    t_window          n_win;

    // both stores are read every cycle at the column of the next word;
    // the data is taken in the cycle after the word is accepted
    mfs_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_ram_upper (
        .i_clk  (i_clk),
        .i_we   (r_v1),
        .i_waddr(r_col1),
        .i_wdata(w_mid),
        .i_raddr(i_col),
        .o_rdata(w_up)
    );

    mfs_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_ram_middle (
        .i_clk  (i_clk),
        .i_we   (r_v1),
        .i_waddr(r_col1),
        .i_wdata(r_px1),
        .i_raddr(i_col),
        .o_rdata(w_mid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_px1  <= i_pixel;
            r_col1 <= i_col;
        end
    end

    always_comb begin
        n_win = r_win;
        for (int k = 0; k < 3; k++) begin
            n_win[k*3]   = r_win[k*3+1];
            n_win[k*3+1] = r_win[k*3+2];
        end
        n_win[2] = w_up;
        n_win[5] = w_mid;
        n_win[8] = r_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_v1) begin
            r_win <= n_win;
        end
    end

    assign o_window = r_win;

endmodule

@@ hdl/mfs_median.sv @@
`timescale 1ns / 1ps

module mfs_median import mfs_pkg::*; (
    input  t_window          i_window,
    output logic [PIX_W-1:0] o_median
);

    logic [RANK_W-1:0] w_rank [WIN_N];

    // rank of each entry, ties broken by position, so exactly one has the middle rank
    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < WIN_N; j++) begin
                if (j != i) begin
                    if ((i_window[j] < i_window[i]) ||
                        ((i_window[j] == i_window[i]) && (j < i))) begin
                        w_rank[i] = w_rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < WIN_N; i++) begin
            if (w_rank[i] == RANK_W'(MED_RANK)) begin
                o_median = o_median | i_window[i];
            end
        end
    end

endmodule

@@ hdl/mfs_fifo.sv @@
`timescale 1ns / 1ps

module mfs_fifo import mfs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output t_result            o_data,
    output logic [FIFO_CW-1:0] o_count
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

@@ hdl/median_filter_3x3_stream_unit.sv @@
`timescale 1ns / 1ps

// 3x3 median filter over a raster-order stream of 8-bit grayscale pixels.
// Input channel: i_valid / i_pixel, the block drives o_stall. Output channel:
// o_valid / o_median_value / o_out_row / o_out_column / o_frame_done, the
// receiver drives i_stall. A word moves at an edge with valid high, stall low.
// Frame size comes from two registers written through i_cfg_we / i_cfg_index /
// i_cfg_data; values are clamped to 3..1024 and take effect on the next pixel.
// Border pixels give no result; every interior pixel gives one word, and the
// last one of a frame carries o_frame_done, after which the position wraps.
// An accepted pixel passes through the window input stage, the window register
// and the result queue. Throughput: one pixel per cycle while o_stall is low,
// set by the window update and the line stores, read at the accepting edge
// and written at the following edge through their own write port.
// A four-word result queue absorbs receiver stalls; o_stall rises once the
// queue plus the two pixels in flight could fill it, so nothing is lost.
// Reset clears position counters, window, queue and sets both sizes to 1024;
// line store contents stay undefined until the first rows are written.
module median_filter_3x3_stream_unit import mfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 o_stall,
    output logic                 o_valid,
    output logic [PIX_W-1:0]     o_median_value,
    output logic [POS_W-1:0]     o_out_row,
    output logic [POS_W-1:0]     o_out_column,
    output logic                 o_frame_done,
    input  logic                 i_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]   r_cfg_width;
    logic [CFG_W-1:0]   r_cfg_height;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic [DIM_W-1:0]   w_w;
    logic [DIM_W-1:0]   w_h;
    logic [DIM_W-1:0]   w_c;
    logic [DIM_W-1:0]   w_r;
    logic               w_accept;
    t_pos_info          n_info;
    t_pos_info          r_info1;
    t_pos_info          r_info2;
    logic               r_v1;
    logic               r_v2;
    t_window            w_window;
    logic [PIX_W-1:0]   w_median;
    t_result            w_push_data;
    t_result            w_head;
    logic               w_push;
    logic               w_pop;
    logic [FIFO_CW-1:0] w_count;
    logic [FIFO_CW:0]   w_reserved;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(RESET_DIM);
            r_cfg_height <= CFG_W'(RESET_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_w = clamp_dim(r_cfg_width, DIM_W'(MAX_WIDTH));
    assign w_h = clamp_dim(r_cfg_height, DIM_W'(MAX_HEIGHT));
    assign w_c = DIM_W'(r_col);
    assign w_r = DIM_W'(r_row);

    // queue slots held by results still on their way count as taken
    assign w_reserved = (FIFO_CW + 1)'(w_count) + (FIFO_CW + 1)'(r_v1)
                      + (FIFO_CW + 1)'(r_v2);
    assign o_stall    = (w_reserved >= (FIFO_CW + 1)'(FIFO_DEPTH));
    assign w_accept   = i_valid && !o_stall;

    // position of the incoming word and what it produces
    always_comb begin
        n_info.emit = (w_r >= DIM_W'(2)) && (w_c >= DIM_W'(2)) &&
                      (w_r < w_h) && (w_c < w_w);
        n_info.done = (w_r == w_h - 1'b1) && (w_c == w_w - 1'b1);
        n_info.row  = POS_W'(w_r - 1'b1);
        n_info.col  = POS_W'(w_c - 1'b1);
        if (w_c + 1'b1 >= w_w) begin
            n_col = '0;
            n_row = (w_r + 1'b1 >= w_h) ? '0 : ROW_W'(w_r + 1'b1);
        end else begin
            n_col = COL_W'(w_c + 1'b1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_v1 <= w_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_info1 <= n_info;
        end
        if (r_v1) begin
            r_info2 <= r_info1;
        end
    end

    mfs_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_pixel (i_pixel),
        .i_col   (r_col),
        .o_window(w_window)
    );

    mfs_median u_median (
        .i_window(w_window),
        .o_median(w_median)
    );

    assign w_push             = r_v2 && r_info2.emit;
    assign w_push_data.median = w_median;
    assign w_push_data.row    = r_info2.row;
    assign w_push_data.col    = r_info2.col;
    assign w_push_data.done   = r_info2.done;
    assign w_pop              = o_valid && !i_stall;

    mfs_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_data),
        .i_pop  (w_pop),
        .o_valid(o_valid),
        .o_data (w_head),
        .o_count(w_count)
    );

    assign o_median_value = w_head.median;
    assign o_out_row      = w_head.row;
    assign o_out_column   = w_head.col;
    assign o_frame_done   = w_head.done;

    // the reservation must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |-> (w_count < FIFO_CW'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // an interior result never lies on the first row or column
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> ((r_info2.row != '0) && (r_info2.col != '0)))
        else $error("result pushed for a border position");

    // every accepted word passes through r_v1 and then reaches the window stage as r_v2
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_v1 ##1 r_v2))
        else $error("accepted word lost in the pipeline");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mfs_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_PIXELS = 450;
    localparam int WIDE_PIXELS   = 40;
    localparam int TALL_PIXELS   = 120;
    localparam int MAX_PRINTED   = 40;
    localparam int LIMIT_NS      = 4_000_000;

    typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_CLUSTER} t_pix_mode;

    class median_scoreboard;
        logic [PIX_W-1:0] upper_row [MAX_WIDTH];
        logic [PIX_W-1:0] middle_row [MAX_WIDTH];
        logic [PIX_W-1:0] win [WIN_N];
        int unsigned      row;
        int unsigned      col;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        t_result          expected [$];
        int               errors;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[i]) begin
                win[i] = '0;
            end
            row        = 0;
            col        = 0;
            width_reg  = CFG_W'(RESET_DIM);
            height_reg = CFG_W'(RESET_DIM);
            errors     = 0;
        endfunction

        static function int unsigned size_in_use(logic [CFG_W-1:0] v, int unsigned hi);
            if (v < MIN_DIM) begin
                return MIN_DIM;
            end
            if (v > hi) begin
                return hi;
            end
            return v;
        endfunction

        function int unsigned cols_in_use();
            return size_in_use(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned rows_in_use();
            return size_in_use(height_reg, MAX_HEIGHT);
        endfunction

        function bit at_frame_start();
            return (row == 0) && (col == 0);
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // walks the position counters forward until they wrap to the frame origin
        function int unsigned pixels_to_frame_start();
            int unsigned r;
            int unsigned c;
            int unsigned n;
            int unsigned w;
            int unsigned h;
            r = row;
            c = col;
            n = 0;
            w = cols_in_use();
            h = rows_in_use();
            while (r != 0 || c != 0) begin
                if (c + 1 >= w) begin
                    c = 0;
                    r = (r + 1 >= h) ? 0 : r + 1;
                end else begin
                    c++;
                end
                n++;
            end
            return n;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH) begin
                width_reg = val;
            end else if (idx == REG_IMAGE_HEIGHT) begin
                height_reg = val;
            end
        endfunction

        // the median is the value with at most four smaller and more than four not larger
        function logic [PIX_W-1:0] median_of_window();
            int lt;
            int le;
            for (int i = 0; i < WIN_N; i++) begin
                lt = 0;
                le = 0;
                for (int j = 0; j < WIN_N; j++) begin
                    if (win[j] < win[i]) lt++;
                    if (win[j] <= win[i]) le++;
                end
                if (lt <= MED_RANK && le > MED_RANK) begin
                    return win[i];
                end
            end
            return '0;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px);
            int unsigned      w;
            int unsigned      h;
            logic [PIX_W-1:0] up;
            logic [PIX_W-1:0] mid;
            t_result          res;
            w   = cols_in_use();
            h   = rows_in_use();
            up  = upper_row[col];
            mid = middle_row[col];
            upper_row[col]  = mid;
            middle_row[col] = px;
            for (int k = 0; k < 3; k++) begin
                win[k * 3]     = win[k * 3 + 1];
                win[k * 3 + 1] = win[k * 3 + 2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = px;
            if (row >= 2 && col >= 2 && row < h && col < w) begin
                res.median = median_of_window();
                res.row    = POS_W'(row - 1);
                res.col    = POS_W'(col - 1);
                res.done   = (row == h - 1) && (col == w - 1);
                expected.push_back(res);
            end
            if (col + 1 >= w) begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end else begin
                col++;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        task check_result(logic [PIX_W-1:0] m, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                          logic d);
            t_result want;
            if (expected.size() == 0) begin
                report($sformatf("unexpected word median %0d at (%0d,%0d)", m, r, c));
                return;
            end
            want = expected.pop_front();
            if (m !== want.median) begin
                report($sformatf("median %0d, want %0d at (%0d,%0d)",
                                 m, want.median, want.row, want.col));
            end
            if (r !== want.row) begin
                report($sformatf("row %0d, want %0d", r, want.row));
            end
            if (c !== want.col) begin
                report($sformatf("column %0d, want %0d", c, want.col));
            end
            if (d !== want.done) begin
                report($sformatf("frame_done %0b, want %0b at (%0d,%0d)",
                                 d, want.done, want.row, want.col));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic [PIX_W-1:0]     i_pixel;
    logic                 o_stall;
    logic                 o_valid;
    logic [PIX_W-1:0]     o_median_value;
    logic [POS_W-1:0]     o_out_row;
    logic [POS_W-1:0]     o_out_column;
    logic                 o_frame_done;
    logic                 i_stall;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    median_scoreboard sb;
    int               burst_left;
    bit               hold_req;
    int               random_sent;
    int               cluster_base;

    median_filter_3x3_stream_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_pixel        (i_pixel),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_median_value (o_median_value),
        .o_out_row      (o_out_row),
        .o_out_column   (o_out_column),
        .o_frame_done   (o_frame_done),
        .i_stall        (i_stall),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // outputs are checked before the input word of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_median_value, o_out_row, o_out_column, o_frame_done);
            end
            if (i_valid && !o_stall) begin
                sb.note_pixel(i_pixel);
            end
        end
    end

    initial begin : receiver
        int seg_left;
        int stall_pct;
        seg_left  = 0;
        stall_pct = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // long hold-off so the result queue fills and the input stalls
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 64);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                seg_left--;
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(t_pix_mode m);
        int v;
        case (m)
            PIX_EXTREME: begin
                return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            PIX_CLUSTER: begin
                v = cluster_base + $urandom_range(0, 6) - 3;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return PIX_W'(v);
            end
            default: begin
                return PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic stream_pixels(input int n, input t_pix_mode m);
        cluster_base = $urandom_range(0, 255);
        for (int i = 0; i < n; i++) begin
            send_pixel(pick_pixel(m));
        end
    endtask

    // idle the input and wait out every pending word plus the pipeline
    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sizes(input bit set_w, input logic [CFG_W-1:0] wv,
                               input bit set_h, input logic [CFG_W-1:0] hv);
        if (set_w) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_IMAGE_WIDTH;
            i_cfg_data  <= wv;
            @(posedge i_clk);
            sb.write_reg(REG_IMAGE_WIDTH, wv);
        end
        if (set_h) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_IMAGE_HEIGHT;
            i_cfg_data  <= hv;
            @(posedge i_clk);
            sb.write_reg(REG_IMAGE_HEIGHT, hv);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_sizes(output bit set_w, output logic [CFG_W-1:0] wv,
                              output bit set_h, output logic [CFG_W-1:0] hv);
        set_w = ($urandom_range(0, 3) != 0);
        set_h = ($urandom_range(0, 3) != 0);
        wv = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 2))
                                         : CFG_W'($urandom_range(3, 12));
        hv = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 2))
                                         : CFG_W'($urandom_range(3, 8));
        // widening mid-frame would read line store entries this frame never wrote
        if (set_w && !sb.at_frame_start()
                && median_scoreboard::size_in_use(wv, MAX_WIDTH) > sb.cols_in_use()) begin
            wv = CFG_W'(sb.cols_in_use());
        end
    endtask

    initial begin
        bit               set_w;
        bit               set_h;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        int               n;

        sb = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pixel     <= '0;
        i_stall     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= '0;
        burst_left   = 0;
        hold_req     = 1'b0;
        random_sent  = 0;
        cluster_base = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame, height below range clamps to three; five of nine are 255
        write_sizes(1'b1, CFG_W'(3), 1'b1, CFG_W'(0));
        for (int i = 0; i < 9; i++) begin
            send_pixel((i % 2) ? 8'h00 : 8'hFF);
        end
        settle();

        // stop at row 1 column 3 of a four wide frame, then narrow to three
        write_sizes(1'b1, CFG_W'(4), 1'b0, '0);
        for (int i = 0; i < 7; i++) begin
            send_pixel(PIX_W'(200 - 23 * i));
        end
        settle();
        // column now past the width: no word for that pixel, the next row starts
        write_sizes(1'b1, CFG_W'(3), 1'b0, '0);
        for (int i = 0; i < 4; i++) begin
            send_pixel(PIX_W'(17 + 40 * i));
        end
        settle();

        while (random_sent < RANDOM_PIXELS) begin
            pick_sizes(set_w, wv, set_h, hv);
            write_sizes(set_w, wv, set_h, hv);
            if (random_sent == 0 || $urandom_range(0, 5) == 0) begin
                hold_req = 1'b1;
            end
            n = $urandom_range(4, 2 * sb.cols_in_use() * sb.rows_in_use() + sb.cols_in_use());
            stream_pixels(n, t_pix_mode'($urandom_range(0, 2)));
            random_sent += n;
            settle();
        end

        stream_pixels(sb.pixels_to_frame_start(), PIX_UNIFORM);
        settle();

        // width above range clamps to the maximum; part of the first row
        write_sizes(1'b1, CFG_W'(2047), 1'b1, CFG_W'(3));
        stream_pixels(WIDE_PIXELS, PIX_UNIFORM);
        settle();

        // narrow to three columns mid-row, then the top of the tallest frame
        write_sizes(1'b1, CFG_W'(1), 1'b1, CFG_W'(MAX_HEIGHT));
        hold_req = 1'b1;
        stream_pixels(TALL_PIXELS, PIX_CLUSTER);
        settle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
